>>> rtl/pga_pkg.sv
// ----------------------------------------------------------------------------
// pga_pkg
// Shared widths, types and helpers of the pairwise gravity accumulator.
// ----------------------------------------------------------------------------
package pga_pkg;

  localparam int NUM_BODIES = 64;
  localparam int IDX_W      = $clog2(NUM_BODIES);

  localparam int BODY_W = 6;
  localparam int POS_W  = 32;
  localparam int DIFF_W = 33;
  localparam int MASS_W = 16;
  localparam int G_W    = 32;
  localparam int FRC_W  = 48;
  localparam int DSQ_W  = 66;
  localparam int ROOT_W = 34;
  localparam int SQR_W  = 37;
  localparam int GM_W   = 48;
  localparam int N_W    = 64;
  localparam int NUM_W  = 97;
  localparam int DEN_W  = 108;
  localparam int ACC_W  = 100;
  localparam int QUO_W  = 64;
  localparam int MA_W   = 96;
  localparam int MB_W   = 34;
  localparam int CH_W   = 32;
  localparam int PRD_W  = CH_W + MB_W;
  localparam int VP_W   = FRC_W + MASS_W + 1;
  localparam int DCNT_W = $clog2(NUM_W);

  localparam logic [FRC_W-1:0] FRC_MAX = {1'b0, {(FRC_W-1){1'b1}}};
  localparam logic [FRC_W-1:0] FRC_MIN = {1'b1, {(FRC_W-1){1'b0}}};

  typedef enum logic [2:0] {
    MS_SQ  = 3'd0,
    MS_GM  = 3'd1,
    MS_N   = 3'd2,
    MS_DEN = 3'd3,
    MS_NUM = 3'd4
  } mul_sel_t;

  typedef struct packed {
    logic       ld_in;
    logic       load_wr;
    logic       mul_en;
    logic       mul_clr;
    mul_sel_t   mul_sel;
    logic [1:0] mul_k;
    logic [1:0] axis;
    logic       lat_dsq;
    logic       sqrt_en;
    logic       lat_gm;
    logic       lat_n;
    logic       lat_den;
    logic       div_start;
    logic       lat_f;
    logic       sel_b;
    logic       mrd;
    logic       mcap_a;
    logic       mcap_b;
    logic       frd;
    logic       fwr_a;
    logic       fwr_b;
    logic       fcap_a;
    logic       fcap_b;
    logic       vel_en;
    logic [2:0] vel_idx;
    logic       vel_wr;
    logic       coinc_set;
  } ctl_t;

  typedef struct packed {
    logic cmd;
    logic dsq_zero;
    logic div_done;
  } sts_t;

  function automatic logic [FRC_W-1:0] sat49(input logic [FRC_W:0] v);
    logic [FRC_W-1:0] r;
    if (v[FRC_W] != v[FRC_W-1]) begin
      r = v[FRC_W] ? FRC_MIN : FRC_MAX;
    end else begin
      r = v[FRC_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/pairwise_gravity_accumulator.sv
// ----------------------------------------------------------------------------
// pairwise_gravity_accumulator
// Table of 64 bodies with mass and three-axis force; pairwise gravity update.
// ----------------------------------------------------------------------------
// Input transfer: drive the in_ fields and raise start; the item is taken at a
// clock edge where start is high and busy is low. busy stays high until the
// result has been shown.
// Result: out_valid is high for exactly one cycle with the velocity fields and
// out_coincident; the receiver cannot stall, so it must take it in that cycle.
// Sequence: a load item goes through S_LOAD to S_DONE. A pair item reads both
// masses, forms the distance square and its root, builds the numerator and
// denominator, runs the divider per axis, updates both force entries and forms
// the velocities; a coincident pair skips to the velocities. The pair time is
// set by the bit-serial divider (97 steps per axis, three axes), the square
// root and the shared 32x34 multiplier that takes one chunk per cycle.
// One item is worked on at a time.
// Configuration: cfg_valid/cfg_ready write cfg_data into the gravitational
// constant; cfg_ready is always high. Write only while the block is idle.
// Reset (rst_n low, synchronous): constant back to 1.0, all force entries read
// as zero, controller idle. Masses must be loaded before use.
// ----------------------------------------------------------------------------
module pairwise_gravity_accumulator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [pga_pkg::BODY_W-1:0]  in_body_a,
  input  logic [pga_pkg::BODY_W-1:0]  in_body_b,
  input  logic [pga_pkg::MASS_W-1:0]  in_mass_value,
  input  logic [pga_pkg::POS_W-1:0]   in_pos_a_x,
  input  logic [pga_pkg::POS_W-1:0]   in_pos_a_y,
  input  logic [pga_pkg::POS_W-1:0]   in_pos_a_z,
  input  logic [pga_pkg::POS_W-1:0]   in_pos_b_x,
  input  logic [pga_pkg::POS_W-1:0]   in_pos_b_y,
  input  logic [pga_pkg::POS_W-1:0]   in_pos_b_z,
  output logic                        out_valid,
  output logic [pga_pkg::FRC_W-1:0]   out_vel_a_x,
  output logic [pga_pkg::FRC_W-1:0]   out_vel_a_y,
  output logic [pga_pkg::FRC_W-1:0]   out_vel_a_z,
  output logic [pga_pkg::FRC_W-1:0]   out_vel_b_x,
  output logic [pga_pkg::FRC_W-1:0]   out_vel_b_y,
  output logic [pga_pkg::FRC_W-1:0]   out_vel_b_z,
  output logic                        out_coincident,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pga_pkg::G_W-1:0]     cfg_data
);

  pga_pkg::ctl_t ctl;
  pga_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  pga_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl),
    .sts       (sts)
  );

  pga_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_data       (cfg_data),
    .in_cmd         (in_cmd),
    .in_body_a      (in_body_a),
    .in_body_b      (in_body_b),
    .in_mass_value  (in_mass_value),
    .in_pos_a_x     (in_pos_a_x),
    .in_pos_a_y     (in_pos_a_y),
    .in_pos_a_z     (in_pos_a_z),
    .in_pos_b_x     (in_pos_b_x),
    .in_pos_b_y     (in_pos_b_y),
    .in_pos_b_z     (in_pos_b_z),
    .out_vel_a_x    (out_vel_a_x),
    .out_vel_a_y    (out_vel_a_y),
    .out_vel_a_z    (out_vel_a_z),
    .out_vel_b_x    (out_vel_b_x),
    .out_vel_b_y    (out_vel_b_y),
    .out_vel_b_z    (out_vel_b_z),
    .out_coincident (out_coincident)
  );

endmodule

>>> rtl/pga_div.sv
// ----------------------------------------------------------------------------
// pga_div
// Restoring bit-serial divider, one quotient bit per cycle, low bits kept.
// ----------------------------------------------------------------------------
module pga_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pga_pkg::NUM_W-1:0]  num,
  input  logic [pga_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [pga_pkg::QUO_W-1:0]  quot
);

  logic                        busy_r;
  logic                        done_r;
  logic [pga_pkg::DCNT_W-1:0]  cnt_r;
  logic [pga_pkg::NUM_W-1:0]   num_r;
  logic [pga_pkg::DEN_W-1:0]   rem_r;
  logic [pga_pkg::QUO_W-1:0]   q_r;
  logic [pga_pkg::DEN_W-1:0]   rem_sh;
  logic                        ge;

  assign rem_sh = {rem_r[pga_pkg::DEN_W-2:0], num_r[pga_pkg::NUM_W-1]};
  assign ge     = rem_sh >= den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == pga_pkg::DCNT_W'(pga_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= num;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sh - den : rem_sh;
      num_r <= {num_r[pga_pkg::NUM_W-2:0], 1'b0};
      q_r   <= {q_r[pga_pkg::QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> rtl/pga_dpath.sv
// ----------------------------------------------------------------------------
// pga_dpath
// Body tables, shared chunked multiplier, square root, divider hookup,
// force update and velocity output stage.
// ----------------------------------------------------------------------------
module pga_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pga_pkg::ctl_t               ctl,
  output pga_pkg::sts_t               sts,
  input  logic                        cfg_we,
  input  logic [pga_pkg::G_W-1:0]     cfg_data,
  input  logic                        in_cmd,
  input  logic [pga_pkg::BODY_W-1:0]  in_body_a,
  input  logic [pga_pkg::BODY_W-1:0]  in_body_b,
  input  logic [pga_pkg::MASS_W-1:0]  in_mass_value,
  input  logic [pga_pkg::POS_W-1:0]   in_pos_a_x,
  input  logic [pga_pkg::POS_W-1:0]   in_pos_a_y,
  input  logic [pga_pkg::POS_W-1:0]   in_pos_a_z,
  input  logic [pga_pkg::POS_W-1:0]   in_pos_b_x,
  input  logic [pga_pkg::POS_W-1:0]   in_pos_b_y,
  input  logic [pga_pkg::POS_W-1:0]   in_pos_b_z,
  output logic [pga_pkg::FRC_W-1:0]   out_vel_a_x,
  output logic [pga_pkg::FRC_W-1:0]   out_vel_a_y,
  output logic [pga_pkg::FRC_W-1:0]   out_vel_a_z,
  output logic [pga_pkg::FRC_W-1:0]   out_vel_b_x,
  output logic [pga_pkg::FRC_W-1:0]   out_vel_b_y,
  output logic [pga_pkg::FRC_W-1:0]   out_vel_b_z,
  output logic                        out_coincident
);

  localparam int FW = pga_pkg::FRC_W;

  logic [pga_pkg::G_W-1:0]            grav_r;
  logic [pga_pkg::IDX_W-1:0]          a_r;
  logic [pga_pkg::IDX_W-1:0]          b_r;
  logic [pga_pkg::IDX_W-1:0]          addr;
  logic [pga_pkg::MASS_W-1:0]         mass_in_r;
  logic [2:0][pga_pkg::POS_W-1:0]     pa;
  logic [2:0][pga_pkg::POS_W-1:0]     pb;
  logic [2:0][pga_pkg::DIFF_W-1:0]    diff;
  logic [2:0][pga_pkg::DIFF_W-1:0]    mag_nxt;
  logic [2:0][pga_pkg::DIFF_W-1:0]    mag_r;
  logic [2:0]                         neg_r;

  logic [pga_pkg::MASS_W-1:0]         mmem [pga_pkg::NUM_BODIES];
  logic [pga_pkg::MASS_W-1:0]         mrd_r;
  logic [pga_pkg::MASS_W-1:0]         ma_r;
  logic [pga_pkg::MASS_W-1:0]         mb_r;

  logic [3*FW-1:0]                    fmem [pga_pkg::NUM_BODIES];
  logic [pga_pkg::NUM_BODIES-1:0]     fvld_r;
  logic [3*FW-1:0]                    frd_r;
  logic                               frd_vld_r;
  logic [2:0][FW-1:0]                 frc_cur;
  logic [2:0][FW-1:0]                 frc_upd;
  logic [3*FW-1:0]                    fwdata;
  logic                               fwr;
  logic [2:0][FW-1:0]                 frc_a_r;
  logic [2:0][FW-1:0]                 frc_b_r;
  logic [2:0][FW-1:0]                 f_r;

  logic [pga_pkg::MA_W-1:0]           mul_a;
  logic [pga_pkg::MB_W-1:0]           mul_b;
  logic [pga_pkg::CH_W-1:0]           chunk;
  logic [pga_pkg::PRD_W-1:0]          prod;
  logic [pga_pkg::ACC_W-1:0]          acc_r;
  logic [pga_pkg::ACC_W-1:0]          acc_nxt;

  logic [pga_pkg::DSQ_W-1:0]          dsq_r;
  logic [2*pga_pkg::ROOT_W-1:0]       sq_src_r;
  logic [pga_pkg::SQR_W-1:0]          sq_rem_r;
  logic [pga_pkg::ROOT_W-1:0]         sq_root_r;
  logic [pga_pkg::SQR_W-1:0]          sq_rem2;
  logic [pga_pkg::SQR_W-1:0]          sq_trial;
  logic [pga_pkg::GM_W-1:0]           gm_r;
  logic [pga_pkg::N_W-1:0]            n_r;
  logic [pga_pkg::DEN_W-1:0]          den_r;
  logic                               div_done;
  logic [pga_pkg::QUO_W-1:0]          quot;
  logic [FW-1:0]                      mag_sat;

  logic signed [FW-1:0]               vfsel;
  logic [pga_pkg::MASS_W-1:0]         vmsel;
  logic signed [pga_pkg::VP_W-1:0]    vprod;
  logic signed [pga_pkg::VP_W-1:0]    vp_r;
  logic [2:0]                         vidx_r;
  logic [pga_pkg::VP_W-13:0]          vq;
  logic [FW-1:0]                      vsat;
  logic [5:0][FW-1:0]                 vel_r;
  logic                               coinc_r;

  assign pa = {in_pos_a_z, in_pos_a_y, in_pos_a_x};
  assign pb = {in_pos_b_z, in_pos_b_y, in_pos_b_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]    = {pb[i][pga_pkg::POS_W-1], pb[i]} - {pa[i][pga_pkg::POS_W-1], pa[i]};
      mag_nxt[i] = diff[i][pga_pkg::DIFF_W-1] ? (~diff[i] + 1'b1) : diff[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= pga_pkg::G_W'(65536);
    end else if (cfg_we) begin
      grav_r <= cfg_data;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (ctl.ld_in) begin
      a_r       <= pga_pkg::IDX_W'(in_body_a % pga_pkg::NUM_BODIES);
      b_r       <= pga_pkg::IDX_W'(in_body_b % pga_pkg::NUM_BODIES);
      mass_in_r <= in_mass_value;
      mag_r     <= mag_nxt;
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= diff[i][pga_pkg::DIFF_W-1];
      end
    end
  end

  assign addr = ctl.sel_b ? b_r : a_r;

  // mass table
  always_ff @(posedge clk) begin
    if (ctl.load_wr) begin
      mmem[a_r] <= mass_in_r;
    end
    if (ctl.mrd) begin
      mrd_r <= mmem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mcap_a) begin
      ma_r <= mrd_r;
    end
    if (ctl.mcap_b) begin
      mb_r <= mrd_r;
    end
  end

  // force table, entries read as zero until first written
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      frc_cur[i] = frd_vld_r ? frd_r[i*FW +: FW] : '0;
      if (ctl.fwr_b) begin
        frc_upd[i] = pga_pkg::sat49({frc_cur[i][FW-1], frc_cur[i]} - {f_r[i][FW-1], f_r[i]});
      end else begin
        frc_upd[i] = pga_pkg::sat49({frc_cur[i][FW-1], frc_cur[i]} + {f_r[i][FW-1], f_r[i]});
      end
    end
  end

  assign fwr    = ctl.load_wr | ctl.fwr_a | ctl.fwr_b;
  assign fwdata = ctl.load_wr ? '0 : frc_upd;

  always_ff @(posedge clk) begin
    if (fwr) begin
      fmem[addr] <= fwdata;
    end
    if (ctl.frd) begin
      frd_r <= fmem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvld_r    <= '0;
      frd_vld_r <= 1'b0;
    end else begin
      if (fwr) begin
        fvld_r[addr] <= 1'b1;
      end
      if (ctl.frd) begin
        frd_vld_r <= fvld_r[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fcap_a) begin
      frc_a_r <= frc_cur;
    end
    if (ctl.fcap_b) begin
      frc_b_r <= frc_cur;
    end
  end

  // shared 32 x 34 multiplier, one chunk of the wide operand per cycle
  always_comb begin
    case (ctl.mul_sel)
      pga_pkg::MS_SQ: begin
        mul_a = pga_pkg::MA_W'(mag_r[ctl.axis]);
        mul_b = pga_pkg::MB_W'(mag_r[ctl.axis]);
      end
      pga_pkg::MS_GM: begin
        mul_a = pga_pkg::MA_W'(grav_r);
        mul_b = pga_pkg::MB_W'(ma_r);
      end
      pga_pkg::MS_N: begin
        mul_a = pga_pkg::MA_W'(gm_r);
        mul_b = pga_pkg::MB_W'(mb_r);
      end
      pga_pkg::MS_DEN: begin
        mul_a = pga_pkg::MA_W'(dsq_r);
        mul_b = sq_root_r;
      end
      pga_pkg::MS_NUM: begin
        mul_a = pga_pkg::MA_W'(n_r);
        mul_b = pga_pkg::MB_W'(mag_r[ctl.axis]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign chunk   = mul_a[{ctl.mul_k, 5'b0} +: pga_pkg::CH_W];
  assign prod    = pga_pkg::PRD_W'(chunk) * pga_pkg::PRD_W'(mul_b);
  assign acc_nxt = (ctl.mul_clr ? '0 : acc_r)
                 + (pga_pkg::ACC_W'(prod) << {ctl.mul_k, 5'b0});

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      acc_r <= acc_nxt;
    end
  end

  // digit-by-digit square root
  assign sq_rem2  = {sq_rem_r[pga_pkg::SQR_W-3:0], sq_src_r[2*pga_pkg::ROOT_W-1 -: 2]};
  assign sq_trial = pga_pkg::SQR_W'({sq_root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (ctl.lat_dsq) begin
      dsq_r     <= acc_r[pga_pkg::DSQ_W-1:0];
      sq_src_r  <= (2*pga_pkg::ROOT_W)'(acc_r[pga_pkg::DSQ_W-1:0]);
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (ctl.sqrt_en) begin
      sq_src_r <= {sq_src_r[2*pga_pkg::ROOT_W-3:0], 2'b00};
      if (sq_rem2 >= sq_trial) begin
        sq_rem_r  <= sq_rem2 - sq_trial;
        sq_root_r <= {sq_root_r[pga_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_r  <= sq_rem2;
        sq_root_r <= {sq_root_r[pga_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lat_gm) begin
      gm_r <= acc_r[pga_pkg::GM_W-1:0];
    end
    if (ctl.lat_n) begin
      n_r <= acc_r[pga_pkg::N_W-1:0];
    end
    if (ctl.lat_den) begin
      den_r <= pga_pkg::DEN_W'({acc_r[pga_pkg::ACC_W-2:0], 8'b0});
    end
  end

  pga_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (acc_r[pga_pkg::NUM_W-1:0]),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign mag_sat = (|quot[pga_pkg::QUO_W-1:FW-1]) ? pga_pkg::FRC_MAX : FW'(quot[FW-2:0]);

  always_ff @(posedge clk) begin
    if (ctl.lat_f) begin
      f_r[ctl.axis] <= neg_r[ctl.axis] ? (~mag_sat + 1'b1) : mag_sat;
    end
  end

  // velocity stage
  always_comb begin
    if (ctl.vel_idx < 3'd3) begin
      vfsel = frc_a_r[ctl.vel_idx[1:0]];
      vmsel = ma_r;
    end else begin
      vfsel = frc_b_r[2'(ctl.vel_idx - 3'd3)];
      vmsel = mb_r;
    end
  end

  assign vprod = vfsel * $signed({1'b0, vmsel});
  assign vq    = vp_r[pga_pkg::VP_W-1:12];

  always_comb begin
    if (vq[pga_pkg::VP_W-13:FW-1] == '0 || vq[pga_pkg::VP_W-13:FW-1] == '1) begin
      vsat = vq[FW-1:0];
    end else begin
      vsat = vq[pga_pkg::VP_W-13] ? pga_pkg::FRC_MIN : pga_pkg::FRC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.vel_en) begin
      vp_r   <= vprod;
      vidx_r <= ctl.vel_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_wr) begin
      vel_r <= '0;
    end else if (ctl.vel_wr) begin
      vel_r[vidx_r] <= vsat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coinc_r <= 1'b0;
    end else if (ctl.ld_in) begin
      coinc_r <= 1'b0;
    end else if (ctl.coinc_set) begin
      coinc_r <= 1'b1;
    end
  end

  assign sts.cmd      = in_cmd;
  assign sts.dsq_zero = (acc_r == '0);
  assign sts.div_done = div_done;

  assign out_vel_a_x    = vel_r[0];
  assign out_vel_a_y    = vel_r[1];
  assign out_vel_a_z    = vel_r[2];
  assign out_vel_b_x    = vel_r[3];
  assign out_vel_b_y    = vel_r[4];
  assign out_vel_b_z    = vel_r[5];
  assign out_coincident = coinc_r;

endmodule

>>> rtl/pga_ctrl.sv
// ----------------------------------------------------------------------------
// pga_ctrl
// Sequencer that walks the datapath through load and pair items.
// ----------------------------------------------------------------------------
module pga_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  output pga_pkg::ctl_t  ctl,
  input  pga_pkg::sts_t  sts
);

  localparam int ST_W = 26;

  typedef enum logic [ST_W-1:0] {
    S_IDLE    = ST_W'(1) << 0,
    S_LOAD    = ST_W'(1) << 1,
    S_MA_RD   = ST_W'(1) << 2,
    S_MB_RD   = ST_W'(1) << 3,
    S_MB_CAP  = ST_W'(1) << 4,
    S_SQ      = ST_W'(1) << 5,
    S_SQ_LAT  = ST_W'(1) << 6,
    S_SQRT    = ST_W'(1) << 7,
    S_GM      = ST_W'(1) << 8,
    S_GM_LAT  = ST_W'(1) << 9,
    S_N       = ST_W'(1) << 10,
    S_N_LAT   = ST_W'(1) << 11,
    S_DEN     = ST_W'(1) << 12,
    S_DEN_LAT = ST_W'(1) << 13,
    S_NUM     = ST_W'(1) << 14,
    S_NUM_LAT = ST_W'(1) << 15,
    S_DIV     = ST_W'(1) << 16,
    S_FA_RD   = ST_W'(1) << 17,
    S_FA_WR   = ST_W'(1) << 18,
    S_FB_RD   = ST_W'(1) << 19,
    S_FB_WR   = ST_W'(1) << 20,
    S_VA_RD   = ST_W'(1) << 21,
    S_VB_RD   = ST_W'(1) << 22,
    S_VB_CAP  = ST_W'(1) << 23,
    S_VEL     = ST_W'(1) << 24,
    S_DONE    = ST_W'(1) << 25
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      axis_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    axis_nxt    = axis_r;
    cnt_nxt     = cnt_r;
    ctl         = '0;
    ctl.mul_sel = pga_pkg::MS_SQ;
    ctl.mul_k   = k_r;
    ctl.axis    = axis_r;
    unique case (state_r)
      S_IDLE: begin
        k_nxt    = '0;
        axis_nxt = '0;
        cnt_nxt  = '0;
        if (start) begin
          ctl.ld_in = 1'b1;
          state_nxt = sts.cmd ? S_MA_RD : S_LOAD;
        end
      end
      S_LOAD: begin
        ctl.load_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_MA_RD: begin
        ctl.mrd   = 1'b1;
        state_nxt = S_MB_RD;
      end
      S_MB_RD: begin
        ctl.mcap_a = 1'b1;
        ctl.mrd    = 1'b1;
        ctl.sel_b  = 1'b1;
        state_nxt  = S_MB_CAP;
      end
      S_MB_CAP: begin
        ctl.mcap_b = 1'b1;
        state_nxt  = S_SQ;
      end
      S_SQ: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = pga_pkg::MS_SQ;
        ctl.mul_clr = (k_r == 2'd0) && (axis_r == 2'd0);
        if (k_r == 2'd1) begin
          k_nxt = '0;
          if (axis_r == 2'd2) begin
            axis_nxt  = '0;
            state_nxt = S_SQ_LAT;
          end else begin
            axis_nxt = axis_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_SQ_LAT: begin
        ctl.lat_dsq = 1'b1;
        cnt_nxt     = '0;
        if (sts.dsq_zero) begin
          ctl.coinc_set = 1'b1;
          state_nxt     = S_VA_RD;
        end else begin
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        ctl.sqrt_en = 1'b1;
        if (cnt_r == 6'(pga_pkg::ROOT_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_GM;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_GM: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = pga_pkg::MS_GM;
        ctl.mul_clr = 1'b1;
        state_nxt   = S_GM_LAT;
      end
      S_GM_LAT: begin
        ctl.lat_gm = 1'b1;
        state_nxt  = S_N;
      end
      S_N: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = pga_pkg::MS_N;
        ctl.mul_clr = (k_r == 2'd0);
        if (k_r == 2'd1) begin
          k_nxt     = '0;
          state_nxt = S_N_LAT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_N_LAT: begin
        ctl.lat_n = 1'b1;
        state_nxt = S_DEN;
      end
      S_DEN: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = pga_pkg::MS_DEN;
        ctl.mul_clr = (k_r == 2'd0);
        if (k_r == 2'd2) begin
          k_nxt     = '0;
          state_nxt = S_DEN_LAT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DEN_LAT: begin
        ctl.lat_den = 1'b1;
        state_nxt   = S_NUM;
      end
      S_NUM: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = pga_pkg::MS_NUM;
        ctl.mul_clr = (k_r == 2'd0);
        if (k_r == 2'd1) begin
          k_nxt     = '0;
          state_nxt = S_NUM_LAT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_NUM_LAT: begin
        ctl.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          ctl.lat_f = 1'b1;
          if (axis_r == 2'd2) begin
            axis_nxt  = '0;
            state_nxt = S_FA_RD;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = S_NUM;
          end
        end
      end
      S_FA_RD: begin
        ctl.frd   = 1'b1;
        state_nxt = S_FA_WR;
      end
      S_FA_WR: begin
        ctl.fwr_a = 1'b1;
        state_nxt = S_FB_RD;
      end
      S_FB_RD: begin
        ctl.frd   = 1'b1;
        ctl.sel_b = 1'b1;
        state_nxt = S_FB_WR;
      end
      S_FB_WR: begin
        ctl.fwr_b = 1'b1;
        ctl.sel_b = 1'b1;
        state_nxt = S_VA_RD;
      end
      S_VA_RD: begin
        ctl.frd   = 1'b1;
        state_nxt = S_VB_RD;
      end
      S_VB_RD: begin
        ctl.fcap_a = 1'b1;
        ctl.frd    = 1'b1;
        ctl.sel_b  = 1'b1;
        state_nxt  = S_VB_CAP;
      end
      S_VB_CAP: begin
        ctl.fcap_b = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_VEL;
      end
      S_VEL: begin
        ctl.vel_en  = (cnt_r < 6'd6);
        ctl.vel_idx = cnt_r[2:0];
        ctl.vel_wr  = (cnt_r != 6'd0);
        if (cnt_r == 6'd6) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DIV)
    else $error("divider finished outside its wait state");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");
  a_fwr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fwr_b |-> $past(state_r) == S_FB_RD)
    else $error("force write without preceding read");
`endif

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// pairwise gravity accumulator testbench
// Drives load and pair commands, keeps its own table of masses and force
// accumulators to predict each result, and compares every strobed result,
// field by field, with the oldest prediction. Runs directed cases, then
// random traffic under three idling patterns and several gravity constants.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIMIT_CYCLES = 3000000;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PAIR = 1'b1;

  typedef struct {
    logic signed [pga_pkg::FRC_W-1:0] vel[6];
    logic                             coinc;
  } vel_result_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_cmd;
  logic [pga_pkg::BODY_W-1:0] in_body_a;
  logic [pga_pkg::BODY_W-1:0] in_body_b;
  logic [pga_pkg::MASS_W-1:0] in_mass_value;
  logic [pga_pkg::POS_W-1:0] in_pos_a_x, in_pos_a_y, in_pos_a_z;
  logic [pga_pkg::POS_W-1:0] in_pos_b_x, in_pos_b_y, in_pos_b_z;
  logic out_valid;
  logic [pga_pkg::FRC_W-1:0] out_vel_a_x, out_vel_a_y, out_vel_a_z;
  logic [pga_pkg::FRC_W-1:0] out_vel_b_x, out_vel_b_y, out_vel_b_z;
  logic out_coincident;
  logic cfg_valid;
  logic cfg_ready;
  logic [pga_pkg::G_W-1:0] cfg_data;

  logic [pga_pkg::G_W-1:0]          grav_g;
  logic [pga_pkg::MASS_W-1:0]       body_mass[pga_pkg::NUM_BODIES];
  logic signed [pga_pkg::FRC_W-1:0] body_force[3][pga_pkg::NUM_BODIES];
  bit                               mass_loaded[pga_pkg::NUM_BODIES];
  vel_result_t                      expected_vel_q[$];
  int                               fail_count;
  int                               cycle_count;
  int                               sender_idle_pct;

  pairwise_gravity_accumulator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_body_a(in_body_a), .in_body_b(in_body_b),
    .in_mass_value(in_mass_value),
    .in_pos_a_x(in_pos_a_x), .in_pos_a_y(in_pos_a_y), .in_pos_a_z(in_pos_a_z),
    .in_pos_b_x(in_pos_b_x), .in_pos_b_y(in_pos_b_y), .in_pos_b_z(in_pos_b_z),
    .out_valid(out_valid),
    .out_vel_a_x(out_vel_a_x), .out_vel_a_y(out_vel_a_y), .out_vel_a_z(out_vel_a_z),
    .out_vel_b_x(out_vel_b_x), .out_vel_b_y(out_vel_b_y), .out_vel_b_z(out_vel_b_z),
    .out_coincident(out_coincident),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [pga_pkg::FRC_W-1:0] clamp48(
      input logic signed [67:0] v);
    if (v > $signed(68'(pga_pkg::FRC_MAX))) return pga_pkg::FRC_MAX;
    if (v < $signed({{20{1'b1}}, pga_pkg::FRC_MIN})) return pga_pkg::FRC_MIN;
    return v[pga_pkg::FRC_W-1:0];
  endfunction

  function automatic logic signed [pga_pkg::FRC_W-1:0] force_to_vel(
      input logic signed [pga_pkg::FRC_W-1:0] f, input logic [pga_pkg::MASS_W-1:0] m);
    logic signed [pga_pkg::MASS_W:0] ms;
    logic signed [67:0] p;
    ms = {1'b0, m};
    p = f * ms;
    return clamp48(p >>> 12);
  endfunction

  // updates the body table and returns the velocities that the item reports
  function automatic vel_result_t apply_gravity_item(
      input logic cmd, input logic [pga_pkg::BODY_W-1:0] a,
      input logic [pga_pkg::BODY_W-1:0] b, input logic [pga_pkg::MASS_W-1:0] mass,
      input logic [pga_pkg::POS_W-1:0] pa[3], input logic [pga_pkg::POS_W-1:0] pb[3]);
    vel_result_t r;
    logic signed [pga_pkg::DIFF_W-1:0] d[3];
    logic [pga_pkg::DIFF_W-1:0] m[3];
    logic [67:0] dsq;
    logic [67:0] cc;
    logic [pga_pkg::ROOT_W-1:0] root;
    logic [pga_pkg::ROOT_W-1:0] c;
    logic [127:0] n;
    logic [127:0] den;
    logic [127:0] mag;
    logic signed [pga_pkg::FRC_W-1:0] f;
    for (int i = 0; i < 6; i++) r.vel[i] = '0;
    r.coinc = 1'b0;
    if (cmd == CMD_LOAD) begin
      body_mass[a] = mass;
      for (int i = 0; i < 3; i++) body_force[i][a] = '0;
      return r;
    end
    dsq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({pb[i][pga_pkg::POS_W-1], pb[i]})
           - $signed({pa[i][pga_pkg::POS_W-1], pa[i]});
      m[i] = d[i] < 0 ? -d[i] : d[i];
      dsq = dsq + 68'(m[i]) * 68'(m[i]);
    end
    if (dsq == 0) begin
      r.coinc = 1'b1;
    end else begin
      root = '0;
      for (int k = pga_pkg::ROOT_W - 1; k >= 0; k--) begin
        c = root | (34'd1 << k);
        cc = 68'(c) * 68'(c);
        if (cc <= dsq) root = c;
      end
      n = 128'(grav_g) * 128'(body_mass[a]) * 128'(body_mass[b]);
      den = (128'(dsq) * 128'(root)) << 8;
      for (int i = 0; i < 3; i++) begin
        mag = (n * 128'(m[i])) / den;
        if (mag > 128'(pga_pkg::FRC_MAX)) mag = 128'(pga_pkg::FRC_MAX);
        f = d[i] < 0 ? -$signed(mag[pga_pkg::FRC_W-1:0]) : $signed(mag[pga_pkg::FRC_W-1:0]);
        body_force[i][a] = clamp48(68'(body_force[i][a]) + 68'(f));
        body_force[i][b] = clamp48(68'(body_force[i][b]) - 68'(f));
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.vel[i] = force_to_vel(body_force[i][a], body_mass[a]);
      r.vel[3 + i] = force_to_vel(body_force[i][b], body_mass[b]);
    end
    return r;
  endfunction

  task automatic send_item(input logic cmd, input logic [pga_pkg::BODY_W-1:0] a,
      input logic [pga_pkg::BODY_W-1:0] b, input logic [pga_pkg::MASS_W-1:0] mass,
      input logic [pga_pkg::POS_W-1:0] pa[3], input logic [pga_pkg::POS_W-1:0] pb[3]);
    while (busy) @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
    in_cmd = cmd;
    in_body_a = a;
    in_body_b = b;
    in_mass_value = mass;
    {in_pos_a_x, in_pos_a_y, in_pos_a_z} = {pa[0], pa[1], pa[2]};
    {in_pos_b_x, in_pos_b_y, in_pos_b_z} = {pb[0], pb[1], pb[2]};
    start = 1'b1;
    // transfer happens at the coming rising edge
    expected_vel_q.push_back(apply_gravity_item(cmd, a, b, mass, pa, pb));
    if (cmd == CMD_LOAD) mass_loaded[a] = 1'b1;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_vel_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_grav_constant(input logic [pga_pkg::G_W-1:0] g);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_data = g;
    cfg_valid = 1'b1;
    while (!cfg_ready) @(negedge clk);
    grav_g = g;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [pga_pkg::BODY_W-1:0] pick_loaded();
    logic [pga_pkg::BODY_W-1:0] x;
    do x = pga_pkg::BODY_W'($urandom_range(pga_pkg::NUM_BODIES - 1));
    while (!mass_loaded[x]);
    return x;
  endfunction

  function automatic logic [pga_pkg::POS_W-1:0] offset_pos(
      input logic [pga_pkg::POS_W-1:0] p);
    int w;
    logic [pga_pkg::POS_W-1:0] delta;
    w = $urandom_range(24);
    delta = $urandom_range(0, (1 << w) - 1);
    if ($urandom_range(3) == 0) return $urandom;
    if ($urandom_range(5) == 0) return p;
    return $urandom_range(1) ? p + delta : p - delta;
  endfunction

  task automatic send_random_item();
    logic [pga_pkg::POS_W-1:0] pa[3];
    logic [pga_pkg::POS_W-1:0] pb[3];
    logic [pga_pkg::MASS_W-1:0] mass;
    mass = pga_pkg::MASS_W'($urandom_range(3) == 0 ?
           ($urandom_range(1) ? 16'hFFFF : 16'h0001) : $urandom);
    for (int i = 0; i < 3; i++) begin
      pa[i] = $urandom;
      pb[i] = offset_pos(pa[i]);
    end
    if ($urandom_range(99) < 15) begin
      send_item(CMD_LOAD, pga_pkg::BODY_W'($urandom), pga_pkg::BODY_W'($urandom),
                mass, pa, pb);
    end else begin
      if ($urandom_range(15) == 0) pb = pa;
      send_item(CMD_PAIR, pick_loaded(), pick_loaded(), pga_pkg::MASS_W'($urandom),
                pa, pb);
    end
  endtask

  task automatic test_load_commands();
    logic [pga_pkg::POS_W-1:0] z[3];
    z = '{default: '0};
    send_item(CMD_LOAD, 6'd0, 6'd63, 16'h0000, z, z);
    send_item(CMD_LOAD, 6'd63, 6'd0, 16'hFFFF, z, z);
    send_item(CMD_LOAD, 6'd1, 6'd0, 16'h1000, z, z);
    send_item(CMD_LOAD, 6'd2, 6'd0, 16'h8000, z, z);
    send_item(CMD_LOAD, 6'd3, 6'd0, 16'h0001, z, z);
  endtask

  task automatic test_pair_cases();
    logic [pga_pkg::POS_W-1:0] pa[3];
    logic [pga_pkg::POS_W-1:0] pb[3];
    pa = '{32'h0, 32'h0, 32'h0};
    pb = '{32'h100, 32'h0, 32'h0};
    send_item(CMD_PAIR, 6'd1, 6'd2, '0, pa, pb);
    pb = '{32'h1, 32'hFFFF_FFFF, 32'h1};
    send_item(CMD_PAIR, 6'd63, 6'd2, '0, pa, pb);
    // force saturation in both directions
    repeat (3) send_item(CMD_PAIR, 6'd63, 6'd2, '0, pb, pa);
    send_item(CMD_PAIR, 6'd63, 6'd63, '0, pa, pb);
    pa = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    pb = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    send_item(CMD_PAIR, 6'd1, 6'd63, '0, pa, pb);
    send_item(CMD_PAIR, 6'd0, 6'd1, '0, pb, pa);
    send_item(CMD_PAIR, 6'd2, 6'd3, '0, pa, pa);
    send_item(CMD_PAIR, 6'd3, 6'd3, '0, pb, pb);
    send_item(CMD_LOAD, 6'd63, 6'd0, 16'h7FFF, pa, pb);
    send_item(CMD_PAIR, 6'd63, 6'd2, '0, pb, pb);
  endtask

  task automatic test_grav_extremes();
    write_grav_constant(32'hFFFF_FFFF);
    test_pair_cases();
    write_grav_constant(32'h0);
    test_pair_cases();
    write_grav_constant(32'h0001_0000);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      send_random_item();
    end
    sender_idle_pct = 0;
  endtask

  always @(posedge clk) begin
    vel_result_t e;
    logic [pga_pkg::FRC_W-1:0] got[6];
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_n && out_valid) begin
      got = '{out_vel_a_x, out_vel_a_y, out_vel_a_z, out_vel_b_x, out_vel_b_y, out_vel_b_z};
      if (expected_vel_q.size() == 0) begin
        $display("%0t: unexpected result", $time);
        fail_count++;
      end else begin
        e = expected_vel_q.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (got[i] !== e.vel[i]) begin
            $display("%0t: vel[%0d] expected %h actual %h", $time, i, e.vel[i], got[i]);
            fail_count++;
          end
        end
        if (out_coincident !== e.coinc) begin
          $display("%0t: coincident expected %b actual %b", $time, e.coinc, out_coincident);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    grav_g = 32'h0001_0000;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_LOAD;
    in_body_a = '0;
    in_body_b = '0;
    in_mass_value = '0;
    {in_pos_a_x, in_pos_a_y, in_pos_a_z} = '0;
    {in_pos_b_x, in_pos_b_y, in_pos_b_z} = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    for (int i = 0; i < pga_pkg::NUM_BODIES; i++) begin
      body_mass[i] = '0;
      mass_loaded[i] = 1'b0;
      for (int k = 0; k < 3; k++) body_force[k][i] = '0;
    end
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_load_commands();
    test_pair_cases();
    test_grav_extremes();
    test_random_traffic(550, 14);
    write_grav_constant($urandom);
    test_random_traffic(550, 86);
    write_grav_constant(32'h0100_0000);
    test_random_traffic(550, 0);
    wait_drained();
    repeat (400) @(negedge clk);
    if (fail_count == 0 && expected_vel_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
